// ===== hdl/qgelu_pkg.sv =====
`timescale 1ns / 1ps

package qgelu_pkg;

    // Input and output beats.
    typedef struct packed {
        logic signed [31:0] accumulator;
        logic               is_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] quant_out;
        logic              last_out;
    } t_out_beat;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_SCALE_MANT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_SCALE_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SCALE_MANT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SCALE_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_OFFSET      = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [23:0] RST_SCALE_MANT  = 24'd8388608;
    localparam logic [5:0]  RST_SCALE_SHIFT = 6'd23;

    // Polynomial constants in Q30.
    localparam logic [29:0] RSQRT2_Q30 = 30'd759250124;
    localparam logic [30:0] CLIP_Q30   = 31'd1899449287;
    localparam logic [28:0] AMAG_Q30   = 29'd310096639;
    localparam logic [30:0] B_Q30      = 31'd1097121908;
    localparam logic [26:0] C_Q30      = 27'd103337496;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;

    localparam logic [5:0] Q30_SHIFT  = 6'd30;
    localparam logic [5:0] HALF_SHIFT = 6'd31;

    // Number of register stages from input to output.
    localparam int unsigned NSTG = 13;

endpackage

// ===== hdl/quantized_gelu_int32_to_int8_core.sv =====
`timescale 1ns / 1ps
// Quantised GELU, one signed 32-bit accumulator in, one int8 result out.
//
// Input channel: i_in_valid / o_in_ready carry a beat holding the accumulator
// and an end-of-tensor flag. Output channel: o_out_valid / i_out_ready carry
// the int8 result, zero point included, with the flag copied through.
// Configuration: i_cfg_valid / o_cfg_ready write i_cfg_data into the register
// chosen by i_cfg_index (0 input mantissa, 1 input shift, 2 output mantissa,
// 3 output shift, 4 zero point); other indexes are ignored. Registers are to
// be written only while no beat is in flight.
//
// The datapath is a 13-stage pipeline whose depth is set by its six
// multipliers, each of which is followed by a register, and by the rounding
// shifts between them, so one beat is taken per cycle when the output is not
// stalled.
//
// Reset is synchronous and active low: it empties the pipeline and loads the
// configuration registers with their defaults. When the receiver stalls, each
// stage holds only while the stage after it is full, so bubbles close up and
// the block keeps taking beats until every stage is occupied.
module quantized_gelu_int32_to_int8_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  qgelu_pkg::t_in_beat                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output qgelu_pkg::t_out_beat               o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [qgelu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qgelu_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int unsigned NSTG = qgelu_pkg::NSTG;
    localparam logic [5:0]  FB6  = 6'(FRAC_BITS);

    // Right shift of a magnitude, rounding half up.
    function automatic logic [63:0] rshift_round(input logic [63:0] m, input logic [5:0] sh);
        logic [63:0] half;
        half = (sh == 6'd0) ? 64'd0 : (64'd1 << (sh - 6'd1));
        return (m + half) >> sh;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // ------------------------------------------------------------------
    logic [23:0]       r_in_mant;
    logic [5:0]        r_in_shift;
    logic [23:0]       r_out_mant;
    logic [5:0]        r_out_shift;
    logic signed [7:0] r_out_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_mant    <= qgelu_pkg::RST_SCALE_MANT;
            r_in_shift   <= qgelu_pkg::RST_SCALE_SHIFT;
            r_out_mant   <= qgelu_pkg::RST_SCALE_MANT;
            r_out_shift  <= qgelu_pkg::RST_SCALE_SHIFT;
            r_out_offset <= 8'sd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qgelu_pkg::CFG_IN_SCALE_MANT:   r_in_mant    <= i_cfg_data;
                qgelu_pkg::CFG_IN_SCALE_SHIFT:  r_in_shift   <= i_cfg_data[5:0];
                qgelu_pkg::CFG_OUT_SCALE_MANT:  r_out_mant   <= i_cfg_data;
                qgelu_pkg::CFG_OUT_SCALE_SHIFT: r_out_shift  <= i_cfg_data[5:0];
                qgelu_pkg::CFG_OUT_OFFSET:      r_out_offset <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables. A stage loads when it is empty or when the stage
    // after it loads, so a stall only holds the stages that are full.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [NSTG-2:0] r_last;

    assign w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;

    genvar g;
    generate
        for (g = 0; g < NSTG - 1; g++) begin : g_en
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end
    endgenerate

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The end-of-tensor flag rides alongside the data.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_last[0] <= i_in_data.is_last;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (w_en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: magnitude of the accumulator times the input mantissa.
    // ------------------------------------------------------------------
    logic [31:0] n0_amag;
    logic [55:0] r0_prod;
    logic        r0_neg;

    assign n0_amag = i_in_data.accumulator[31] ? (~i_in_data.accumulator + 32'd1)
                                               : i_in_data.accumulator;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_prod <= 56'(n0_amag) * 56'(r_in_mant);
            r0_neg  <= i_in_data.accumulator[31];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: align to Q(FRAC_BITS) and saturate. The limit is one larger
    // for negative values. A zero magnitude is treated as positive.
    // ------------------------------------------------------------------
    logic [32:0] n1_lim;
    logic [63:0] n1_shr;
    logic [63:0] n1_shl;
    logic [5:0]  n1_lsh;
    logic [31:0] n1_xmag;
    logic [31:0] r1_xmag;
    logic        r1_neg;

    always_comb begin
        n1_lim  = r0_neg ? 33'h080000000 : 33'h07FFFFFFF;
        n1_lsh  = FB6 - r_in_shift;
        n1_shr  = rshift_round(64'(r0_prod), r_in_shift - FB6);
        n1_shl  = 64'(r0_prod) << n1_lsh;
        if (r_in_shift >= FB6) begin
            n1_xmag = (n1_shr > 64'(n1_lim)) ? n1_lim[31:0] : n1_shr[31:0];
        end else begin
            n1_xmag = (64'(r0_prod) > 64'(n1_lim >> n1_lsh)) ? n1_lim[31:0] : n1_shl[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_xmag <= n1_xmag;
            r1_neg  <= r0_neg && (n1_xmag != 32'd0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: |x| / sqrt(2).
    // ------------------------------------------------------------------
    logic [61:0] r2_vp;
    logic [31:0] r2_xmag;
    logic        r2_neg;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_vp   <= 62'(r1_xmag) * 62'(qgelu_pkg::RSQRT2_Q30);
            r2_xmag <= r1_xmag;
            r2_neg  <= r1_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: into Q30 and clamp at the knee of the erf approximation.
    // ------------------------------------------------------------------
    logic [63:0] n3_vr;
    logic [30:0] r3_v;
    logic [31:0] r3_xmag;
    logic        r3_neg;

    assign n3_vr = rshift_round(64'(r2_vp), FB6);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_v    <= (n3_vr > 64'(qgelu_pkg::CLIP_Q30)) ? qgelu_pkg::CLIP_Q30 : n3_vr[30:0];
            r3_xmag <= r2_xmag;
            r3_neg  <= r2_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |A| * v.
    // ------------------------------------------------------------------
    logic [59:0] r4_av;
    logic [30:0] r4_v;
    logic [31:0] r4_xmag;
    logic        r4_neg;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_av   <= 60'(qgelu_pkg::AMAG_Q30) * 60'(r3_v);
            r4_v    <= r3_v;
            r4_xmag <= r3_xmag;
            r4_neg  <= r3_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: B + A*v. A is negative, so its magnitude is subtracted.
    // ------------------------------------------------------------------
    logic [63:0] n5_av;
    logic [30:0] r5_s1;
    logic [30:0] r5_v;
    logic [31:0] r5_xmag;
    logic        r5_neg;

    assign n5_av = rshift_round(64'(r4_av), qgelu_pkg::Q30_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_s1   <= qgelu_pkg::B_Q30 - n5_av[30:0];
            r5_v    <= r4_v;
            r5_xmag <= r4_xmag;
            r5_neg  <= r4_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: (B + A*v) * v.
    // ------------------------------------------------------------------
    logic [61:0] r6_sv;
    logic [31:0] r6_xmag;
    logic        r6_neg;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_sv   <= 62'(r5_s1) * 62'(r5_v);
            r6_xmag <= r5_xmag;
            r6_neg  <= r5_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: add C, restore the sign and form 1 + erf. Near the clamp the
    // polynomial can exceed one, so 1 + erf may go slightly negative.
    // ------------------------------------------------------------------
    logic [63:0]        n7_yr;
    logic [32:0]        n7_y;
    logic signed [33:0] n7_onepe;
    logic [33:0]        n7_omag;
    logic [31:0]        r7_omag;
    logic               r7_oneneg;
    logic [31:0]        r7_xmag;
    logic               r7_neg;

    always_comb begin
        n7_yr    = rshift_round(64'(r6_sv), qgelu_pkg::Q30_SHIFT);
        n7_y     = n7_yr[32:0] + 33'(qgelu_pkg::C_Q30);
        n7_onepe = r6_neg ? (34'(qgelu_pkg::ONE_Q30) - 34'(n7_y))
                          : (34'(qgelu_pkg::ONE_Q30) + 34'(n7_y));
        n7_omag  = n7_onepe[33] ? (~n7_onepe + 34'd1) : n7_onepe;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_omag   <= n7_omag[31:0];
            r7_oneneg <= n7_onepe[33];
            r7_xmag   <= r6_xmag;
            r7_neg    <= r6_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: |x| * |1 + erf|.
    // ------------------------------------------------------------------
    logic [63:0] r8_xo;
    logic        r8_neg;
    logic        r8_oneneg;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_xo     <= 64'(r7_xmag) * 64'(r7_omag);
            r8_neg    <= r7_neg;
            r8_oneneg <= r7_oneneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: halve and drop the Q30 of 1 + erf, giving GELU in
    // Q(FRAC_BITS). A zero result carries no sign.
    // ------------------------------------------------------------------
    logic [63:0] n9_gr;
    logic [31:0] r9_gmag;
    logic        r9_gneg;

    assign n9_gr = rshift_round(r8_xo, qgelu_pkg::HALF_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_gmag <= n9_gr[31:0];
            r9_gneg <= (r8_neg != r8_oneneg) && (n9_gr[31:0] != 32'd0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: times the output mantissa.
    // ------------------------------------------------------------------
    logic [55:0] r10_qm;
    logic        r10_gneg;

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r10_qm   <= 56'(r9_gmag) * 56'(r_out_mant);
            r10_gneg <= r9_gneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: output shift with rounding, then clamp to int8. A total
    // shift past 63 gives zero.
    // ------------------------------------------------------------------
    logic [6:0]        n11_osh;
    logic [63:0]       n11_qmag;
    logic signed [7:0] n11_q;
    logic signed [7:0] r11_q;

    always_comb begin
        n11_osh  = {1'b0, r_out_shift} + {1'b0, FB6};
        n11_qmag = n11_osh[6] ? 64'd0 : rshift_round(64'(r10_qm), n11_osh[5:0]);
        if (r10_gneg) begin
            n11_q = (n11_qmag > 64'd128) ? -8'sd128 : (~n11_qmag[7:0] + 8'd1);
        end else begin
            n11_q = (n11_qmag > 64'd127) ? 8'sd127 : n11_qmag[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r11_q <= n11_q;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: add the zero point with saturation into the output register.
    // ------------------------------------------------------------------
    logic signed [8:0]     n12_sum;
    logic signed [7:0]     n12_q;
    qgelu_pkg::t_out_beat  r12_out;

    always_comb begin
        n12_sum = {r11_q[7], r11_q} + {r_out_offset[7], r_out_offset};
        if (n12_sum > 9'sd127) begin
            n12_q = 8'sd127;
        end else if (n12_sum < -9'sd128) begin
            n12_q = -8'sd128;
        end else begin
            n12_q = n12_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r12_out.quant_out <= n12_q;
            r12_out.last_out  <= r_last[NSTG-2];
        end
    end

    assign o_out_data = r12_out;

endmodule

// ===== hdl/qgelu_checker.sv =====
`timescale 1ns / 1ps

module qgelu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input qgelu_pkg::t_out_beat            o_out_data,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    // A held result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat withdrawn while stalled");

    // Reset leaves the pipeline empty.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    // With nothing waiting at the output every stage can move, so input is taken.
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind quantized_gelu_int32_to_int8_core qgelu_checker u_qgelu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 16;

    // Fixed-point constants of the GELU datapath, all in Q30.
    localparam logic [63:0] K_RSQRT2 = 64'd759250124;
    localparam logic [63:0] K_CLIP   = 64'd1899449287;
    localparam logic [63:0] K_AMAG   = 64'd310096639;
    localparam logic [63:0] K_B      = 64'd1097121908;
    localparam logic [63:0] K_C      = 64'd103337496;
    localparam longint      K_ONE    = 64'sd1073741824;

    // The highest register index; indexes above the zero point are ignored by the block.
    localparam logic [qgelu_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = 3'd7;

    // The watchdog gives up after this many cycles in which no beat moves on any channel.
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_ready;
    qgelu_pkg::t_in_beat             in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    qgelu_pkg::t_out_beat            out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [qgelu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qgelu_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    quantized_gelu_int32_to_int8_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the configuration registers, updated on every accepted write beat.
    logic [23:0]       sh_in_mant   = qgelu_pkg::RST_SCALE_MANT;
    logic [5:0]        sh_in_shift  = qgelu_pkg::RST_SCALE_SHIFT;
    logic [23:0]       sh_out_mant  = qgelu_pkg::RST_SCALE_MANT;
    logic [5:0]        sh_out_shift = qgelu_pkg::RST_SCALE_SHIFT;
    logic signed [7:0] sh_offset    = '0;

    qgelu_pkg::t_in_beat  pending_beats[$];
    qgelu_pkg::t_out_beat gelu_due[$];

    logic hold_sender = 1'b0;
    logic in_idle_en  = 1'b1;
    logic out_idle_en = 1'b1;
    int   in_gap = 0;
    int   out_stall = 0;
    int   quiet_cycles = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   reg_writes = 0;
    int   errors = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Right shift of a magnitude, rounding half up.
    function automatic logic [63:0] round_shr(logic [63:0] m, int unsigned sh);
        if (sh == 0)
            return m;
        return (m + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Expected int8 GELU result, zero point included, for one accumulator under the
    // current shadow configuration.
    function automatic logic [7:0] gelu_int8(logic [31:0] acc);
        logic [63:0]  amag, lim, prod, xmag, v, s1, y, omag, gmag, qm, qmag;
        logic         xneg, oneneg, gneg;
        longint       onepe;
        int           q;
        int unsigned  ish, osh, l;
        xneg = acc[31];
        amag = xneg ? (64'h1_0000_0000 - {32'd0, acc}) : {32'd0, acc};
        lim  = xneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        prod = amag * {40'd0, sh_in_mant};
        ish  = sh_in_shift;
        // Dequantise into Q16.16 with saturation of the magnitude.
        if (ish >= FRAC) begin
            xmag = round_shr(prod, ish - FRAC);
            if (xmag > lim)
                xmag = lim;
        end else begin
            l = FRAC - ish;
            xmag = (prod > (lim >> l)) ? lim : (prod << l);
        end
        // A zero value takes the positive branch of erf.
        if (xmag == 0)
            xneg = 1'b0;
        v = round_shr(xmag * K_RSQRT2, FRAC);
        if (v > K_CLIP)
            v = K_CLIP;
        s1 = K_B - round_shr(K_AMAG * v, 30);
        y  = round_shr(s1 * v, 30) + K_C;
        onepe  = xneg ? (K_ONE - longint'(y)) : (K_ONE + longint'(y));
        oneneg = onepe < 0;
        omag   = oneneg ? 64'(-onepe) : 64'(onepe);
        gmag   = round_shr(xmag * omag, 31);
        gneg   = (xneg != oneneg) && (gmag != 0);
        // Output scaling; a total shift past 63 leaves nothing.
        osh  = int'(sh_out_shift) + FRAC;
        qm   = gmag * {40'd0, sh_out_mant};
        qmag = (osh > 63) ? 64'd0 : round_shr(qm, osh);
        if (gneg)
            q = (qmag > 128) ? -128 : -int'(qmag);
        else
            q = (qmag > 127) ? 127 : int'(qmag);
        q = q + int'(sh_offset);
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    // Sender: presents queued beats, with random bursts of idle cycles, and records the
    // expected result of every beat at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_valid && in_ready) begin
                gelu_due.push_back(qgelu_pkg::t_out_beat'{
                    quant_out: gelu_int8(in_data.accumulator),
                    last_out: in_data.is_last});
                beats_in <= beats_in + 1;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (in_idle_en && $urandom_range(0, 9) == 0) begin
                    in_gap   <= $urandom_range(1, 16) - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() != 0 && !hold_sender) begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls in random bursts and checks each result beat against the oldest
    // expectation.
    always @(posedge i_clk) begin : receiver
        qgelu_pkg::t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                beats_out <= beats_out + 1;
                if (gelu_due.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: result beat with nothing expected, actual %0d last %0b",
                             $time, $signed(out_data.quant_out), out_data.last_out);
                end else begin
                    want = gelu_due.pop_front();
                    if (want.quant_out !== out_data.quant_out) begin
                        errors = errors + 1;
                        $display("%0t: quant_out expected %0d actual %0d", $time,
                                 $signed(want.quant_out), $signed(out_data.quant_out));
                    end
                    if (want.last_out !== out_data.last_out) begin
                        errors = errors + 1;
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 want.last_out, out_data.last_out);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else if (out_idle_en && $urandom_range(0, 9) == 0) begin
                out_stall <= $urandom_range(1, 16) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, gelu_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // One write beat on the configuration channel; the shadow copy follows on acceptance.
    task automatic write_reg(logic [qgelu_pkg::CFG_IDX_W-1:0] idx,
                             logic [qgelu_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            qgelu_pkg::CFG_IN_SCALE_MANT:   sh_in_mant   = data[23:0];
            qgelu_pkg::CFG_IN_SCALE_SHIFT:  sh_in_shift  = data[5:0];
            qgelu_pkg::CFG_OUT_SCALE_MANT:  sh_out_mant  = data[23:0];
            qgelu_pkg::CFG_OUT_SCALE_SHIFT: sh_out_shift = data[5:0];
            qgelu_pkg::CFG_OUT_OFFSET:      sh_offset    = data[7:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // A register word whose low w bits are the value and whose unused bits are noise.
    function automatic logic [qgelu_pkg::CFG_DAT_W-1:0] cfg_word(
        logic [qgelu_pkg::CFG_DAT_W-1:0] val, int w);
        logic [qgelu_pkg::CFG_DAT_W-1:0] mask;
        mask = (24'd1 << w) - 24'd1;
        return (24'($urandom) & ~mask) | (val & mask);
    endfunction

    task automatic queue_beat(logic [31:0] acc, logic last);
        pending_beats.push_back(qgelu_pkg::t_in_beat'{accumulator: acc, is_last: last});
    endtask

    // Waits until the sender has nothing left and every expected result has come back.
    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || gelu_due.size() != 0)
            @(negedge i_clk);
    endtask

    // A random accumulator spread over all magnitudes, with the corners mixed in.
    function automatic logic [31:0] random_acc();
        logic [31:0] a;
        int          k;
        case ($urandom_range(0, 9))
            0: a = $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: a = 32'h0000_0000;
                    1: a = 32'h0000_0001;
                    2: a = 32'hFFFF_FFFF;
                    3: a = 32'h7FFF_FFFF;
                    default: a = 32'h8000_0000;
                endcase
            end
            default: begin
                k = $urandom_range(0, 31);
                a = $urandom & ((32'd1 << k) - 32'd1);
                if ($urandom_range(0, 1) == 1)
                    a = -a;
            end
        endcase
        return a;
    endfunction

    // Writes a fresh random setting. A wild setting takes any register value; otherwise
    // the scales are chosen so that results spread across the int8 range.
    task automatic pick_setting(bit wild);
        if (wild) begin
            write_reg(qgelu_pkg::CFG_IN_SCALE_MANT, 24'($urandom));
            write_reg(qgelu_pkg::CFG_IN_SCALE_SHIFT, cfg_word(24'($urandom_range(0, 63)), 6));
            write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT, 24'($urandom));
            write_reg(qgelu_pkg::CFG_OUT_SCALE_SHIFT, cfg_word(24'($urandom_range(0, 63)), 6));
        end else begin
            write_reg(qgelu_pkg::CFG_IN_SCALE_MANT,
                      24'($urandom_range(24'h10_0000, 24'hFF_FFFF)));
            write_reg(qgelu_pkg::CFG_IN_SCALE_SHIFT, cfg_word(24'($urandom_range(16, 40)), 6));
            write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT,
                      24'($urandom_range(24'h10_0000, 24'hFF_FFFF)));
            write_reg(qgelu_pkg::CFG_OUT_SCALE_SHIFT, cfg_word(24'($urandom_range(18, 28)), 6));
        end
        write_reg(qgelu_pkg::CFG_OUT_OFFSET, cfg_word(24'($urandom_range(0, 255)), 8));
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(qgelu_pkg::CFG_OUT_OFFSET + 3'd1, CFG_IDX_TOP)),
                      24'($urandom));
    endtask

    // A phase of random beats; with a pause, the sender holds off half way through until
    // the block has handed back every result.
    task automatic random_phase(int n, bit pause);
        int i;
        @(negedge i_clk);
        for (i = 0; i < n / 2; i++)
            queue_beat(random_acc(), 1'($urandom_range(0, 1)));
        if (pause) begin
            while (pending_beats.size() != 0)
                @(negedge i_clk);
            hold_sender <= 1'b1;
        end
        for (i = n / 2; i < n; i++)
            queue_beat(random_acc(), 1'($urandom_range(0, 1)));
        if (pause) begin
            while (in_valid || gelu_due.size() != 0)
                @(negedge i_clk);
            hold_sender <= 1'b0;
        end
        drain();
    endtask

    initial begin
        int ph;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: unit scales, so the accumulator is the real value. Covers zero,
        // small values both sides and dequantisation saturation at both ends.
        queue_beat(32'd0, 1'b0);
        queue_beat(32'd1, 1'b1);
        queue_beat(-32'sd1, 1'b0);
        queue_beat(32'd2, 1'b1);
        queue_beat(-32'sd2, 1'b0);
        queue_beat(32'd3, 1'b0);
        queue_beat(-32'sd4, 1'b1);
        queue_beat(32'd100, 1'b0);
        queue_beat(-32'sd100, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'h8000_0000, 1'b1);
        drain();

        // Largest scales, no input shift: the left shift saturates at once, and the
        // zero point at its top clamps the sum.
        write_reg(qgelu_pkg::CFG_IN_SCALE_MANT, 24'hFF_FFFF);
        write_reg(qgelu_pkg::CFG_IN_SCALE_SHIFT, 24'hFF_FFC0);
        write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT, 24'hFF_FFFF);
        write_reg(qgelu_pkg::CFG_OUT_SCALE_SHIFT, 24'hFF_FFC0);
        write_reg(qgelu_pkg::CFG_OUT_OFFSET, 24'hFF_FF7F);
        @(negedge i_clk);
        queue_beat(32'd1, 1'b1);
        queue_beat(-32'sd1, 1'b0);
        queue_beat(32'd0, 1'b1);
        queue_beat(32'h8000_0000, 1'b0);
        drain();

        // Zero mantissas, largest shifts and the lowest zero point; the ignored indexes
        // are written with all ones and must leave the setting alone.
        write_reg(qgelu_pkg::CFG_IN_SCALE_MANT, 24'd0);
        write_reg(qgelu_pkg::CFG_IN_SCALE_SHIFT, 24'd63);
        write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT, 24'd0);
        write_reg(qgelu_pkg::CFG_OUT_SCALE_SHIFT, 24'd63);
        write_reg(qgelu_pkg::CFG_OUT_OFFSET, 24'h00_0080);
        for (ph = qgelu_pkg::CFG_OUT_OFFSET + 1; ph <= CFG_IDX_TOP; ph++)
            write_reg(ph[qgelu_pkg::CFG_IDX_W-1:0], 24'hFF_FFFF);
        @(negedge i_clk);
        queue_beat(32'h7FFF_FFFF, 1'b1);
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'd5, 1'b1);
        drain();

        // Output shift past the end with a working input scale: everything rounds to
        // zero and only the zero point remains.
        write_reg(qgelu_pkg::CFG_IN_SCALE_MANT, qgelu_pkg::RST_SCALE_MANT);
        write_reg(qgelu_pkg::CFG_IN_SCALE_SHIFT, 24'(qgelu_pkg::RST_SCALE_SHIFT));
        write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT, 24'hFF_FFFF);
        @(negedge i_clk);
        queue_beat(32'd20000, 1'b0);
        drain();

        // Unit scales with a large zero point, clamping after the offset at the top.
        write_reg(qgelu_pkg::CFG_OUT_SCALE_MANT, qgelu_pkg::RST_SCALE_MANT);
        write_reg(qgelu_pkg::CFG_OUT_SCALE_SHIFT, 24'(qgelu_pkg::RST_SCALE_SHIFT));
        write_reg(qgelu_pkg::CFG_OUT_OFFSET, 24'd100);
        @(negedge i_clk);
        queue_beat(32'd50, 1'b1);
        queue_beat(-32'sd2, 1'b0);
        queue_beat(32'd3, 1'b1);
        queue_beat(32'd0, 1'b0);
        drain();

        // Random phases, each under its own setting. Some run without idling, two hold
        // the sender off mid-stream, and the final stretch has no idling at all.
        for (ph = 0; ph < 14; ph++) begin
            pick_setting($urandom_range(0, 3) == 0);
            in_idle_en  <= !(ph == 5 || ph >= 12);
            out_idle_en <= !(ph == 5 || ph >= 12);
            random_phase(110, ph == 3 || ph == 8);
        end

        repeat (qgelu_pkg::NSTG * 2) @(posedge i_clk);
        $display("Checked %0d results from %0d accumulator beats under %0d register writes,",
                 beats_out, beats_in, reg_writes);
        $display("from reset scales through saturating, zeroed and random settings.");
        if (errors == 0 && gelu_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qgelu_pkg.sv
hdl/quantized_gelu_int32_to_int8_core.sv
hdl/qgelu_checker.sv
sim/testbench.sv
